// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Fixed field widths and reset values of the LFU page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int PAGE_FIELD_BITS = 16;
   localparam int FRAME_IDX_BITS  = 3;
   localparam int FAULT_BITS      = 32;
   localparam int CFG_BITS        = 4;

   localparam logic [CFG_BITS-1:0] CFG_FRAMES_RESET = 4'd8;

endpackage

// ===== rtl/lfu_ram.sv =====
// ----------------------------------------------------------------------------
// lfu_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lfu_page_replacement_top.sv =====
// Scan: the frame RAM read port scans one frame per cycle over the n enabled
//   frames (frames_in_use clamped to 1..FRAMES), so the scan length sets the
//   transaction rate. A new request is taken only once the previous one has
//   left the update state, which waits while the output register is stalled.
// Reset: synchronous, active high; all frames go invalid, the fault counter
//   clears and frames_in_use returns to 8. No clearing pass is needed.
// ----------------------------------------------------------------------------
// lfu_page_replacement_top
// LFU page replacement: looks up a page among the enabled frames, bumps the
// use count on a hit, otherwise fills the least used frame (lowest index on
// a tie) and counts the fault.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_page_replacement_top #(
   parameter int FRAMES     = 8,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_wr_en,
   input  logic [lfu_pkg::CFG_BITS-1:0]          csr_wr_data,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lfu_pkg::PAGE_FIELD_BITS-1:0]   req_page_number,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [lfu_pkg::FRAME_IDX_BITS-1:0]    rsp_frame_index,
   output logic                                  rsp_evicted_valid,
   output logic [lfu_pkg::PAGE_FIELD_BITS-1:0]   rsp_evicted_page,
   output logic [lfu_pkg::FAULT_BITS-1:0]        rsp_fault_count
);

   import lfu_pkg::*;

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W = $clog2(FRAMES + 1);
   localparam int RAM_W = PAGE_BITS + COUNT_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Registers
   state_type              state_ff;
   logic [CFG_BITS-1:0]    frames_ff;
   logic [PAGE_BITS-1:0]   page_ff;
   logic [CNT_W-1:0]       n_ff;
   logic [CNT_W-1:0]       iss_ff;
   logic                   chk_ff;
   logic [IDX_W-1:0]       chk_idx_ff;
   logic                   hit_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic [COUNT_BITS-1:0]  hit_uses_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [COUNT_BITS-1:0]  best_uses_ff;
   logic                   best_valid_ff;
   logic [PAGE_BITS-1:0]   best_page_ff;
   logic [FRAMES-1:0]      valid_ff;
   logic [FAULT_BITS-1:0]  fault_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [FRAME_IDX_BITS-1:0] rsp_frame_index_ff;
   logic                   rsp_evicted_valid_ff;
   logic [PAGE_FIELD_BITS-1:0] rsp_evicted_page_ff;
   logic [FAULT_BITS-1:0]  rsp_fault_count_ff;

   // Next values
   logic [CNT_W-1:0]       n_in;
   logic [FAULT_BITS-1:0]  fault_in;
   logic [COUNT_BITS-1:0]  hit_uses_in;

   // Scan and RAM signals
   logic                   req_accept;
   logic                   rsp_accept;
   logic                   upd_go;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [RAM_W-1:0]       rd_data;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [RAM_W-1:0]       wr_data;
   logic                   cur_valid;
   logic [PAGE_BITS-1:0]   cur_page;
   logic [COUNT_BITS-1:0]  cur_uses;
   logic                   cur_match;
   logic                   take_min;
   logic                   scan_last;
   logic [IDX_W-1:0]       sel_idx;

   // ------------------------------------------------------------------------
   // Handshakes. A new request is taken only when no scan or update is in
   // flight; a finished response may still wait in the output register.
   // ------------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   // Update only once the output register can take the new response.
   assign upd_go     = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);

   // Clamp frames_in_use to 1..FRAMES and latch it with the transaction.
   always_comb begin
      if (frames_ff == '0) begin
         n_in = CNT_W'(1);
      end else if (int'(frames_ff) > FRAMES) begin
         n_in = CNT_W'(FRAMES);
      end else begin
         n_in = CNT_W'(frames_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Frame RAM: {page, use count} per frame. Valid bits live in flops so a
   // frame that was never filled reads as count zero and its page is ignored.
   // Reads happen only during the scan and writes only during the update, so
   // no forwarding is needed between them.
   // ------------------------------------------------------------------------
   assign rd_en   = (state_ff == ST_SCAN) && (iss_ff < n_ff);
   assign rd_addr = iss_ff[IDX_W-1:0];

   lfu_ram #(
      .WIDTH (RAM_W),
      .DEPTH (FRAMES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Check the frame whose read data arrived this cycle.
   assign cur_valid = valid_ff[chk_idx_ff];
   assign cur_page  = rd_data[RAM_W-1:COUNT_BITS];
   assign cur_uses  = cur_valid ? rd_data[COUNT_BITS-1:0] : '0;
   assign cur_match = cur_valid && (cur_page == page_ff);
   // Strict less-than keeps the lowest index on a tie.
   assign take_min  = (chk_idx_ff == '0) || (cur_uses < best_uses_ff);
   assign scan_last = chk_ff && (CNT_W'(chk_idx_ff) == (n_ff - CNT_W'(1)));

   // Saturating increments
   assign hit_uses_in = (hit_uses_ff == '1) ? hit_uses_ff : hit_uses_ff + COUNT_BITS'(1);
   assign fault_in    = (fault_ff == '1) ? fault_ff : fault_ff + FAULT_BITS'(1);

   // Hit: bump the count of the matching frame. Miss: load the page with a
   // count of one into the least used frame.
   assign sel_idx = hit_ff ? hit_idx_ff : best_idx_ff;
   assign wr_en   = upd_go;
   assign wr_addr = sel_idx;
   assign wr_data = hit_ff ? {page_ff, hit_uses_in} : {page_ff, COUNT_BITS'(1)};

   // ------------------------------------------------------------------------
   // Sequencer: idle, scan (issue reads, compare returning data), update.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frames_ff    <= CFG_FRAMES_RESET;
         chk_ff       <= 1'b0;
         valid_ff     <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            frames_ff <= csr_wr_data;
         end

         // Drop the response once the far side takes it, unless the next
         // one loads in the same cycle.
         if (rsp_accept && !upd_go) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  page_ff  <= PAGE_BITS'(req_page_number);
                  n_ff     <= n_in;
                  iss_ff   <= '0;
                  chk_ff   <= 1'b0;
                  hit_ff   <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end

            ST_SCAN: begin
               // Advance the read pointer; tag the data that returns next cycle.
               if (rd_en) begin
                  iss_ff <= iss_ff + CNT_W'(1);
               end
               chk_ff     <= rd_en;
               chk_idx_ff <= rd_addr;

               if (chk_ff) begin
                  if (cur_match && !hit_ff) begin
                     hit_ff      <= 1'b1;
                     hit_idx_ff  <= chk_idx_ff;
                     hit_uses_ff <= rd_data[COUNT_BITS-1:0];
                  end
                  if (take_min) begin
                     best_idx_ff   <= chk_idx_ff;
                     best_uses_ff  <= cur_uses;
                     best_valid_ff <= cur_valid;
                     best_page_ff  <= cur_page;
                  end
               end

               if (scan_last) begin
                  state_ff <= ST_UPDATE;
               end
            end

            ST_UPDATE: begin
               if (upd_go) begin
                  if (!hit_ff) begin
                     valid_ff[best_idx_ff] <= 1'b1;
                     fault_ff              <= fault_in;
                  end
                  rsp_valid_ff         <= 1'b1;
                  rsp_hit_ff           <= hit_ff;
                  rsp_frame_index_ff   <= FRAME_IDX_BITS'(sel_idx);
                  rsp_evicted_valid_ff <= !hit_ff && best_valid_ff;
                  rsp_evicted_page_ff  <= (!hit_ff && best_valid_ff) ?
                                          PAGE_FIELD_BITS'(best_page_ff) : '0;
                  rsp_fault_count_ff   <= hit_ff ? fault_ff : fault_in;
                  state_ff             <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_index_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_count   = rsp_fault_count_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `ASSERT_SAME(a_accept_no_scan, req_accept, !chk_ff && (state_ff == ST_IDLE),
                "request accepted while a scan is in flight")
   `ASSERT_SAME(a_sel_in_range, upd_go, (CNT_W'(sel_idx) < n_ff),
                "selected frame lies outside the enabled frames")
   `ASSERT_NEXT(a_hit_keeps_faults, upd_go && hit_ff, fault_ff == $past(fault_ff),
                "fault counter changed on a hit")
   `ASSERT_SAME(a_hit_no_evict, rsp_valid_ff, !(rsp_hit_ff && rsp_evicted_valid_ff),
                "response reports both a hit and an eviction")

endmodule

// ===== test/lfu_page_replacement_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_page_replacement_top_tb
// Self-checking bench for the LFU page replacement block. A directed table
// covers the reset state, extreme page numbers, frame count clamping, frames
// left outside the enabled range and duplicate matches. Random transactions
// with page locality follow. Every response is checked field by field
// against an in-bench LFU predictor or a directed row's hand-typed outcome.
// ----------------------------------------------------------------------------
module lfu_page_replacement_top_tb;

   import lfu_pkg::*;

   localparam int  CLK_HALF      = 6;
   localparam int  NUM_FRAMES    = 8;
   localparam int  SETTLE_CYCLES = 12;
   localparam int  BLOCK_ITEMS   = 65;
   localparam int  BLOCKS        = 10;
   localparam int  POOL_SIZE     = 6;
   localparam int  DIR_ROWS      = 24;
   localparam logic [15:0] USE_MAX   = 16'hFFFF;
   localparam logic [31:0] FAULT_MAX = 32'hFFFF_FFFF;

   // One response transaction, laid out field by field.
   typedef struct packed {
      logic                       hit;
      logic [FRAME_IDX_BITS-1:0]  frame_index;
      logic                       evicted_valid;
      logic [PAGE_FIELD_BITS-1:0] evicted_page;
      logic [FAULT_BITS-1:0]      fault_count;
   } page_outcome_type;

   typedef enum logic [1:0] {
      ROW_REF,
      ROW_CFG
   } row_kind_type;

   // Directed row: a page reference (optionally with a hand-typed outcome)
   // or a frames_in_use write.
   typedef struct packed {
      row_kind_type               kind;
      logic [PAGE_FIELD_BITS-1:0] value;
      logic                       typed;
      page_outcome_type           outcome;
   } dir_row_type;

   // ------------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // ------------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [CFG_BITS-1:0]        csr_wr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [PAGE_FIELD_BITS-1:0] req_page_number = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_hit;
   logic [FRAME_IDX_BITS-1:0]  rsp_frame_index;
   logic                       rsp_evicted_valid;
   logic [PAGE_FIELD_BITS-1:0] rsp_evicted_page;
   logic [FAULT_BITS-1:0]      rsp_fault_count;

   // Side band that travels with the request payload: a typed outcome
   // replaces the predicted one when req_typed is set.
   logic                       req_typed = 1'b0;
   page_outcome_type           req_typed_outcome = '0;

   // Idle rates in percent, changed per phase by the stimulus process.
   int                         req_idle_pct = 0;
   int                         rsp_idle_pct = 0;
   int                         mismatch_count = 0;

   // Predictor copy of the frame table.
   logic                       frame_used  [NUM_FRAMES];
   logic [PAGE_FIELD_BITS-1:0] frame_tag   [NUM_FRAMES];
   logic [15:0]                frame_count [NUM_FRAMES];
   logic [FAULT_BITS-1:0]      fault_tally;
   logic [CFG_BITS-1:0]        frames_cfg;

   page_outcome_type           pending_outcomes [$];
   dir_row_type                directed_rows [DIR_ROWS];

   lfu_page_replacement_top DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count)
   );

   // ------------------------------------------------------------------------
   // Clock, and a hard limit on run time at several times the slowest
   // correct run
   // ------------------------------------------------------------------------
   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   task automatic clear_frames();
      for (int j = 0; j < NUM_FRAMES; j++) begin
         frame_used[j]  = 1'b0;
         frame_tag[j]   = '0;
         frame_count[j] = '0;
      end
      fault_tally = '0;
      frames_cfg  = CFG_FRAMES_RESET;
   endtask

   // Resolve one page reference against the frame table and advance it.
   function automatic page_outcome_type resolve_reference(
      input logic [PAGE_FIELD_BITS-1:0] page);
      page_outcome_type o;
      int            n;
      int            sel;
      logic          found;
      logic [15:0]   best;
      o     = '0;
      n     = (frames_cfg == 0) ? 1 : ((frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg);
      sel   = 0;
      found = 1'b0;
      // lowest matching index wins when several frames hold the page
      for (int j = 0; j < n; j++) begin
         if (!found && frame_used[j] && frame_tag[j] == page) begin
            found = 1'b1;
            sel   = j;
         end
      end
      if (found) begin
         if (frame_count[sel] != USE_MAX)
            frame_count[sel]++;
      end else begin
         // least used frame, ties to the lowest index
         best = frame_count[0];
         for (int j = 1; j < n; j++) begin
            if (frame_count[j] < best) begin
               best = frame_count[j];
               sel  = j;
            end
         end
         if (frame_used[sel]) begin
            o.evicted_valid = 1'b1;
            o.evicted_page  = frame_tag[sel];
         end
         frame_used[sel]  = 1'b1;
         frame_tag[sel]   = page;
         frame_count[sel] = 16'd1;
         if (fault_tally != FAULT_MAX)
            fault_tally++;
      end
      o.hit         = found;
      o.frame_index = sel[FRAME_IDX_BITS-1:0];
      o.fault_count = fault_tally;
      return o;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: every signal is sampled at the rising edge, before the NBAs of
   // that edge land, so the bench and the DUT see the same cycle.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      page_outcome_type predicted;
      page_outcome_type want;
      if (reset) begin
         clear_frames();
         pending_outcomes.delete();
      end else begin
         if (csr_wr_en)
            frames_cfg = csr_wr_data;
         // Accepted request: advance the predictor, queue what to expect.
         if (req_valid && !req_stall) begin
            predicted = resolve_reference(req_page_number);
            pending_outcomes.push_back(req_typed ? req_typed_outcome : predicted);
         end
         // Accepted response: compare with the oldest expectation.
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual hit=%0b frame=%0d",
                        $time, rsp_hit, rsp_frame_index);
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("hit", want.hit, rsp_hit);
               check_field("frame_index", want.frame_index, rsp_frame_index);
               check_field("evicted_valid", want.evicted_valid, rsp_evicted_valid);
               check_field("evicted_page", want.evicted_page, rsp_evicted_page);
               check_field("fault_count", want.fault_count, rsp_fault_count);
            end
         end
      end
   end

   // Receiver back-pressure: stall at the current phase's rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // ------------------------------------------------------------------------
   // Stimulus tasks
   // ------------------------------------------------------------------------
   // Present one page reference and hold it until it is accepted.
   task automatic send_page(input logic [PAGE_FIELD_BITS-1:0] page, input logic typed,
                            input page_outcome_type want);
      req_valid         <= 1'b1;
      req_page_number   <= page;
      req_typed         <= typed;
      req_typed_outcome <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait until every outstanding response has come back,
   // then let the pipeline settle.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // frames_in_use is only written with the block idle.
   task automatic write_frames(input logic [CFG_BITS-1:0] value);
      drain_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Gap after a transaction: now and then hold off until the block is
   // empty, otherwise drop valid for a short random gap at the sender's rate.
   task automatic pace_sender();
      if (req_idle_pct != 0 && $urandom_range(0, 99) < 2) begin
         drain_block();
      end else if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------------
   // Main stimulus
   // ------------------------------------------------------------------------
   initial begin
      logic [PAGE_FIELD_BITS-1:0] pool [POOL_SIZE];
      logic [PAGE_FIELD_BITS-1:0] page;
      logic [CFG_BITS-1:0]        cfg_value;

      // Directed table. The first rows, taken straight from reset with all
      // eight frames enabled, carry hand-typed outcomes.
      directed_rows = '{
         {ROW_REF, 16'h0000, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd1},
         {ROW_REF, 16'hFFFF, 1'b1, 1'b0, 3'd1, 1'b0, 16'h0000, 32'd2},
         {ROW_REF, 16'h0000, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd2},
         {ROW_REF, 16'h5555, 1'b1, 1'b0, 3'd2, 1'b0, 16'h0000, 32'd3},
         {ROW_REF, 16'hAAAA, 1'b1, 1'b0, 3'd3, 1'b0, 16'h0000, 32'd4},
         {ROW_REF, 16'h1234, 1'b1, 1'b0, 3'd4, 1'b0, 16'h0000, 32'd5},
         {ROW_REF, 16'h8001, 1'b1, 1'b0, 3'd5, 1'b0, 16'h0000, 32'd6},
         {ROW_REF, 16'h7FFE, 1'b1, 1'b0, 3'd6, 1'b0, 16'h0000, 32'd7},
         {ROW_REF, 16'h00FF, 1'b1, 1'b0, 3'd7, 1'b0, 16'h0000, 32'd8},
         // table full: least used frame with lowest index is evicted
         {ROW_REF, 16'h4321, 1'b1, 1'b0, 3'd1, 1'b1, 16'hFFFF, 32'd9},
         {ROW_REF, 16'h4321, 1'b0, 53'd0},
         {ROW_REF, 16'hFFFF, 1'b0, 53'd0},
         // zero frames acts as one
         {ROW_CFG, 16'd0,    1'b0, 53'd0},
         {ROW_REF, 16'h5555, 1'b0, 53'd0},
         {ROW_REF, 16'hAAAA, 1'b0, 53'd0},
         // above the frame count acts as all frames; frame 0 and frame 3
         // both hold the same page now, and the outside frames come back
         {ROW_CFG, 16'd15,   1'b0, 53'd0},
         {ROW_REF, 16'hAAAA, 1'b0, 53'd0},
         {ROW_REF, 16'h1234, 1'b0, 53'd0},
         // page resident only outside the enabled range misses
         {ROW_CFG, 16'd3,    1'b0, 53'd0},
         {ROW_REF, 16'h8001, 1'b0, 53'd0},
         {ROW_REF, 16'h0001, 1'b0, 53'd0},
         {ROW_CFG, 16'd8,    1'b0, 53'd0},
         {ROW_REF, 16'hFFFF, 1'b0, 53'd0},
         {ROW_REF, 16'h7FFE, 1'b0, 53'd0}
      };

      // Hold reset from time zero, then release it once for the whole run.
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase one: sender idles rarely, receiver stalls often.
      req_idle_pct = 9;
      rsp_idle_pct = 55;

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_CFG) begin
            write_frames(directed_rows[r].value[CFG_BITS-1:0]);
         end else begin
            send_page(directed_rows[r].value, directed_rows[r].typed,
                      directed_rows[r].outcome);
            pace_sender();
         end
      end

      // Random phases: the first block of each phase uses an extreme frame
      // count. References come mostly from a small pool so that hits and
      // LFU evictions dominate, with some fully random pages mixed in.
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               req_idle_pct = 9;
               rsp_idle_pct = 55;
            end
            1: begin
               req_idle_pct = 55;
               rsp_idle_pct = 9;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int b = 0; b < BLOCKS; b++) begin
            if (b == 0)
               cfg_value = (p == 0) ? 4'd1 : ((p == 1) ? 4'd8 : 4'd15);
            else
               cfg_value = CFG_BITS'($urandom_range(0, 15));
            write_frames(cfg_value);
            for (int k = 0; k < POOL_SIZE; k++)
               pool[k] = PAGE_FIELD_BITS'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) == 0)
               pool[0] = 16'h0000;
            if ($urandom_range(0, 3) == 0)
               pool[1] = 16'hFFFF;
            for (int i = 0; i < BLOCK_ITEMS; i++) begin
               if ($urandom_range(0, 99) < 75)
                  page = pool[$urandom_range(0, POOL_SIZE - 1)];
               else
                  page = PAGE_FIELD_BITS'($urandom_range(0, 65535));
               send_page(page, 1'b0, '0);
               pace_sender();
            end
         end
      end

      // Wait for the last responses, plus a margin for stray ones.
      drain_block();

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
